// ----- hdl/assert_macros.svh -----
// Assertion macros used by the checker file of the decoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk, skipped while rst is high.
`define SC2A_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition never holds at a rising edge of clk.
`define SC2A_ASSERT_NEVER(label, cond, msg) \
  `SC2A_ASSERT(label, !(cond), msg)

`endif

// ----- hdl/sc2a_pkg.sv -----
// Types, key codes and character tables of the scan code decoder.
package sc2a_pkg;

  // Modifier flags kept in the flag memory.
  typedef struct packed {
    logic lshift;
    logic rshift;
    logic caps;
    logic ctrl;
    logic alt;
  } flags_t;

  localparam int FLAGS_W = $bits(flags_t);

  // Set-1 make and break codes of the modifier keys.
  localparam logic [7:0] CODE_CTRL_MAKE    = 8'd29;
  localparam logic [7:0] CODE_CTRL_BREAK   = 8'd157;
  localparam logic [7:0] CODE_LSHIFT_MAKE  = 8'd42;
  localparam logic [7:0] CODE_LSHIFT_BREAK = 8'd170;
  localparam logic [7:0] CODE_RSHIFT_MAKE  = 8'd54;
  localparam logic [7:0] CODE_RSHIFT_BREAK = 8'd182;
  localparam logic [7:0] CODE_ALT_MAKE     = 8'd56;
  localparam logic [7:0] CODE_ALT_BREAK    = 8'd184;
  localparam logic [7:0] CODE_CAPS_TOGGLE  = 8'd58;

  localparam logic [6:0] CHAR_CARET = 7'h5e;
  localparam logic [6:0] CHAR_STAR  = 7'h2a;

  // Tables cover codes 0..63; codes 59..63 carry no character.
  localparam int TBL_DEPTH = 64;

  localparam logic [6:0] LOWER_TBL [TBL_DEPTH] = '{
    7'h00, 7'h00, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
    7'h37, 7'h38, 7'h39, 7'h30, 7'h2d, 7'h3d, 7'h00, 7'h09,
    7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
    7'h6f, 7'h70, 7'h5b, 7'h5d, 7'h00, 7'h00, 7'h61, 7'h73,
    7'h64, 7'h66, 7'h67, 7'h68, 7'h6a, 7'h6b, 7'h6c, 7'h3b,
    7'h27, 7'h60, 7'h00, 7'h5c, 7'h7a, 7'h78, 7'h63, 7'h76,
    7'h62, 7'h6e, 7'h6d, 7'h2c, 7'h2e, 7'h2f, 7'h00, 7'h2a,
    7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
  };

  localparam logic [6:0] SHIFT_TBL [TBL_DEPTH] = '{
    7'h00, 7'h00, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5e,
    7'h26, 7'h2a, 7'h28, 7'h29, 7'h5f, 7'h2b, 7'h00, 7'h09,
    7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
    7'h4f, 7'h50, 7'h7b, 7'h7d, 7'h00, 7'h00, 7'h41, 7'h53,
    7'h44, 7'h46, 7'h47, 7'h48, 7'h4a, 7'h4b, 7'h4c, 7'h3a,
    7'h22, 7'h7e, 7'h00, 7'h7c, 7'h5a, 7'h58, 7'h43, 7'h56,
    7'h42, 7'h4e, 7'h4d, 7'h3c, 7'h3e, 7'h3f, 7'h00, 7'h2a,
    7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
  };

  // Swap the case of a letter when en is set; leave other characters alone.
  function automatic logic [6:0] flip_case(input logic [6:0] c, input logic en);
    logic is_alpha;
    is_alpha = ((c >= 7'h41) && (c <= 7'h5a)) || ((c >= 7'h61) && (c <= 7'h7a));
    return (en && is_alpha) ? (c ^ 7'h20) : c;
  endfunction

endpackage

// ----- hdl/sc2a_ram.sv -----
// Generic single-port-write, registered-read RAM.
module sc2a_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hdl/scan_code_to_ascii_decoder_top.sv -----
// Top level of the PS/2 set-1 scan code to ASCII decoder.

// Turns one set-1 scan code per input transfer into zero, one or two ASCII
// results. Modifier make/break codes (shift, ctrl, alt) and the caps lock
// toggle update flags kept in a one-entry flag RAM; they and every release
// or non-character code give no result. A character key gives one result
// chosen from the lower or shifted table, with caps lock swapping letter
// case; in password mode shown_char is '*' while stored_char holds the real
// character. With ctrl held a key gives '^' and then the upper-case-letter
// character, with alt '^' and then the lower-case character, both unmasked;
// last_of_run marks the final result of a scan code. Timing: the flag RAM
// is read when a code is taken and written back when the code retires, with
// the write forwarded to a code taken at the same edge. A new code is taken
// every cycle while the output does not stall; a caret pair holds the
// decode stage for both results, as the output register takes one result
// per cycle. A result waits in that output register while the next code is
// already being taken. After reset the flag RAM needs no clearing: an entry
// never written reads as all flags clear.
module scan_code_to_ascii_decoder_top import sc2a_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wen,
  input  logic       cfg_wdata,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] scan_code,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [6:0] stored_char,
  output logic [6:0] shown_char,
  output logic       last_of_run
);

  localparam int FLAG_DEPTH = 1;
  localparam int FLAG_AW    = 1;
  localparam logic [FLAG_AW-1:0] FLAG_ADDR = '0;

  logic password_mode;

  // Decode stage.
  logic       s1_valid;
  logic [7:0] s1_code;
  logic       s1_phase;     // 0: first result, 1: character after the caret
  logic       s1_fwd;       // flags were written at the edge this code was read
  logic       ram_init;     // flag RAM written at least once since reset
  flags_t     fwd_flags;

  logic [FLAGS_W-1:0] ram_rdata;
  flags_t flags_cur;
  flags_t flags_next;

  logic       in_fire;
  logic       out_take;
  logic       s1_leave;
  logic       has_char;
  logic       pair;
  logic       res_last;
  logic [5:0] tbl_idx;
  logic [6:0] lower_c;
  logic [6:0] shift_c;
  logic [6:0] plain_c;
  logic [6:0] pair_c;
  logic [6:0] res_stored;
  logic [6:0] res_shown;

  // Configuration: one bit, to be written while idle; the block itself does not enforce this.
  always_ff @(posedge clk) begin
    if (rst) begin
      password_mode <= 1'b0;
    end else if (cfg_wen) begin
      password_mode <= cfg_wdata;
    end
  end

  assign in_fire  = in_valid && in_ready;
  assign out_take = !out_valid || out_ready;

  // Flag RAM: read on transfer in, write back when the code retires.
  sc2a_ram #(
    .WIDTH (FLAGS_W),
    .DEPTH (FLAG_DEPTH)
  ) u_flag_ram (
    .clk   (clk),
    .we    (s1_leave),
    .waddr (FLAG_ADDR),
    .wdata (flags_next),
    .re    (in_fire),
    .raddr (FLAG_ADDR),
    .rdata (ram_rdata)
  );

  // Forward a write that landed at the read edge; an unwritten entry is clear.
  always_comb begin
    if (s1_fwd) begin
      flags_cur = fwd_flags;
    end else if (ram_init) begin
      flags_cur = flags_t'(ram_rdata);
    end else begin
      flags_cur = '0;
    end
  end

  // Modifier updates.
  always_comb begin
    flags_next = flags_cur;
    case (s1_code)
      CODE_CTRL_MAKE:    flags_next.ctrl   = 1'b1;
      CODE_CTRL_BREAK:   flags_next.ctrl   = 1'b0;
      CODE_LSHIFT_MAKE:  flags_next.lshift = 1'b1;
      CODE_LSHIFT_BREAK: flags_next.lshift = 1'b0;
      CODE_RSHIFT_MAKE:  flags_next.rshift = 1'b1;
      CODE_RSHIFT_BREAK: flags_next.rshift = 1'b0;
      CODE_ALT_MAKE:     flags_next.alt    = 1'b1;
      CODE_ALT_BREAK:    flags_next.alt    = 1'b0;
      CODE_CAPS_TOGGLE:  flags_next.caps   = !flags_cur.caps;
      default:           flags_next = flags_cur;
    endcase
  end

  // Character lookup. Codes carrying a character never touch the flags,
  // so the current flags select the table.
  assign tbl_idx  = s1_code[5:0];
  assign lower_c  = LOWER_TBL[tbl_idx];
  assign shift_c  = SHIFT_TBL[tbl_idx];
  assign has_char = (s1_code[7:6] == 2'b00) && (lower_c != 7'h00);
  assign plain_c  = flip_case((flags_cur.lshift || flags_cur.rshift) ? shift_c : lower_c,
                              flags_cur.caps);
  assign pair     = flags_cur.ctrl || flags_cur.alt;
  assign pair_c   = flags_cur.ctrl ? flip_case(lower_c, 1'b1) : lower_c;

  always_comb begin
    if (pair) begin
      res_stored = s1_phase ? pair_c : CHAR_CARET;
      res_shown  = res_stored;
    end else begin
      res_stored = plain_c;
      res_shown  = password_mode ? CHAR_STAR : plain_c;
    end
  end

  assign res_last = !pair || s1_phase;
  assign s1_leave = s1_valid && (!has_char || (out_take && res_last));
  assign in_ready = !s1_valid || s1_leave;

  // Decode stage control: hold on a stalled result, advance the phase of a
  // caret pair, drop the code once its last result is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_phase <= 1'b0;
      s1_fwd   <= 1'b0;
      ram_init <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid <= 1'b1;
        s1_phase <= 1'b0;
        s1_fwd   <= s1_leave;
      end else if (s1_leave) begin
        s1_valid <= 1'b0;
      end else if (s1_valid && has_char && out_take) begin
        s1_phase <= 1'b1;
      end
      if (s1_leave) begin
        ram_init <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_code <= scan_code;
    end
    if (s1_leave) begin
      fwd_flags <= flags_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_take) begin
      out_valid <= s1_valid && has_char;
    end
  end

  always_ff @(posedge clk) begin
    if (out_take && s1_valid && has_char) begin
      stored_char <= res_stored;
      shown_char  <= res_shown;
      last_of_run <= res_last;
    end
  end

endmodule

// ----- hdl/sc2a_checker.sv -----
// Port-level checks of the scan code decoder and their bind.
`include "assert_macros.svh"

module sc2a_checker import sc2a_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [6:0] stored_char,
  input logic [6:0] shown_char,
  input logic       last_of_run
);

  logic out_stall;
  logic caret_out;
  logic caret_taken;
  logic echo_differs;

  assign out_stall    = out_valid && !out_ready;
  assign caret_out    = (stored_char == CHAR_CARET) && (shown_char == CHAR_CARET);
  assign caret_taken  = out_valid && out_ready && !last_of_run;
  assign echo_differs = (shown_char != stored_char) &&
                        !((shown_char == CHAR_STAR) && last_of_run);

  // A waiting result holds until it is taken.
  `SC2A_ASSERT(a_out_hold, out_stall |=> out_valid && $stable(stored_char), "waiting result changed")

  // The first result of a pair is always the caret, unmasked.
  `SC2A_ASSERT(a_caret_first, out_valid && !last_of_run |-> caret_out, "pair opens without a caret")

  // The character of a pair follows its caret in the next cycle.
  `SC2A_ASSERT(a_pair_next, caret_taken |=> out_valid && last_of_run, "caret without its character")

  // Echo differs from the stored character only as a mask on a single result.
  `SC2A_ASSERT_NEVER(a_mask_only, out_valid && echo_differs, "echo differs from stored character")

endmodule

bind scan_code_to_ascii_decoder_top sc2a_checker u_sc2a_checker (.*);
